// ===== sv/ppcf_pkg.sv =====
// ----------------------------------------------------------------------------
// ppcf_pkg
// Shared types and constants for the pwm pulse capture block with failsafe
// and watchdog detection.
// ----------------------------------------------------------------------------
package ppcf_pkg;

    // default sizing
    localparam int CHANNELS_DEF   = 4;
    localparam int QUEUE_DEPTH    = 2;

    // failsafe detection
    localparam int FS_RUN_LIMIT   = 20;
    localparam int FS_TOL_US      = 10;
    localparam int PULSE_MAX      = 65535;
    localparam int RUN_W          = 5;

    // field widths
    localparam int CH_FIELD_W     = 2;
    localparam int TS_W           = 32;
    localparam int PULSE_W        = 17;
    localparam int FS_W           = 17;
    localparam int WD_W           = 25;

    // configuration bank
    localparam int CFG_CH         = 4;
    localparam int APB_ADDR_W     = 5;
    localparam int APB_DATA_W     = 32;
    localparam logic [2:0] REG_FS_CH0 = 3'd0;
    localparam logic [2:0] REG_WD_CH0 = 3'd4;

    // result kinds
    localparam logic KIND_PULSE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [1:0] {
        MODE_RISE  = 2'd0,
        MODE_FALL  = 2'd1,
        MODE_QUERY = 2'd2
    } t_mode;

    typedef logic [CFG_CH-1:0][FS_W-1:0] t_fs_bank;
    typedef logic [CFG_CH-1:0][WD_W-1:0] t_wd_bank;

    // classified item handed from front to back
    typedef struct packed {
        t_mode                 mode;
        logic [CH_FIELD_W-1:0] ch;
        logic                  ch_ok;
        logic [TS_W-1:0]       ts;
    } t_cmd;

    // one result
    typedef struct packed {
        logic                  kind;
        logic [CH_FIELD_W-1:0] ch;
        logic [PULSE_W-1:0]    pulse;
        logic                  lost;
        logic                  fsa;
    } t_result;

endpackage

// ===== sv/ppcf_fifo.sv =====
// ----------------------------------------------------------------------------
// ppcf_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module ppcf_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = ppcf_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    import ppcf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== sv/ppcf_cfg.sv =====
// ----------------------------------------------------------------------------
// ppcf_cfg
// APB register bank holding the failsafe pulse and watchdog limits.
// ----------------------------------------------------------------------------
module ppcf_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ppcf_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ppcf_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ppcf_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output ppcf_pkg::t_fs_bank                  o_fs,
    output ppcf_pkg::t_wd_bank                  o_wd
);
    import ppcf_pkg::*;

    t_fs_bank   r_fs;
    t_wd_bank   r_wd;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign o_fs    = r_fs;
    assign o_wd    = r_wd;

    // register writes, both banks reset to the disabled value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fs <= '1;
            r_wd <= '1;
        end else if (wr_en) begin
            if (reg_idx < REG_WD_CH0) begin
                r_fs[reg_idx[1:0]] <= pwdata[FS_W-1:0];
            end else begin
                r_wd[reg_idx[1:0]] <= pwdata[WD_W-1:0];
            end
        end
    end

    // read back, sign extended
    always_comb begin
        if (reg_idx < REG_WD_CH0) begin
            prdata = APB_DATA_W'($signed(r_fs[reg_idx[1:0]]));
        end else begin
            prdata = APB_DATA_W'($signed(r_wd[reg_idx[1:0]]));
        end
    end

endmodule

// ===== sv/ppcf_front.sv =====
// ----------------------------------------------------------------------------
// ppcf_front
// Accepts input items, drops those that cause nothing and queues the rest
// for the execution side.
// ----------------------------------------------------------------------------
module ppcf_front #(
    parameter int CHANNELS    = ppcf_pkg::CHANNELS_DEF,
    parameter int QUEUE_DEPTH = ppcf_pkg::QUEUE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    output logic                              o_full,
    input  logic [1:0]                        i_mode,
    input  logic [ppcf_pkg::CH_FIELD_W-1:0]   i_channel,
    input  logic [ppcf_pkg::TS_W-1:0]         i_timestamp_us,
    input  logic                              i_cmd_pop,
    output ppcf_pkg::t_cmd                    o_cmd,
    output logic                              o_cmd_empty
);
    import ppcf_pkg::*;

    t_cmd                 cmd;
    logic                 ch_ok;
    logic                 keep;
    logic [$bits(t_cmd)-1:0] cmd_q;

    assign ch_ok = (32'(i_channel) < CHANNELS);

    // classify: edges on absent channels and the unused mode vanish here
    always_comb begin
        case (i_mode)
            MODE_RISE, MODE_FALL: keep = ch_ok;
            MODE_QUERY:           keep = 1'b1;
            default:              keep = 1'b0;
        endcase
        cmd.mode  = t_mode'(i_mode);
        cmd.ch    = i_channel;
        cmd.ch_ok = ch_ok;
        cmd.ts    = i_timestamp_us;
    end

    // command queue between front and back
    ppcf_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && keep),
        .i_data  (cmd),
        .o_full  (o_full),
        .i_pop   (i_cmd_pop),
        .o_data  (cmd_q),
        .o_empty (o_cmd_empty)
    );

    assign o_cmd = t_cmd'(cmd_q);

endmodule

// ===== sv/ppcf_back.sv =====
// ----------------------------------------------------------------------------
// ppcf_back
// Executes queued items against the per-channel capture state and queues
// the results for the receiver.
// ----------------------------------------------------------------------------
module ppcf_back #(
    parameter int CHANNELS    = ppcf_pkg::CHANNELS_DEF,
    parameter int QUEUE_DEPTH = ppcf_pkg::QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ppcf_pkg::t_cmd       i_cmd,
    input  logic                 i_cmd_empty,
    output logic                 o_cmd_pop,
    input  ppcf_pkg::t_fs_bank   i_fs,
    input  ppcf_pkg::t_wd_bank   i_wd,
    output ppcf_pkg::t_result    o_res,
    output logic                 o_res_empty,
    input  logic                 i_res_pop
);
    import ppcf_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [TS_W-1:0]    r_rise_time  [CHANNELS];
    logic [PULSE_W-1:0] r_last_pulse [CHANNELS];
    logic [RUN_W-1:0]   r_fs_run     [CHANNELS];

    logic [CH_W-1:0]          idx;
    logic [TS_W-1:0]          diff;
    logic [15:0]              width;
    logic signed [FS_W:0]     fs_x, fs_lo, fs_hi, w_x;
    logic [FS_W-1:0]          fs;
    logic [WD_W-1:0]          wd;
    logic                     in_band;
    logic                     lost, fsa;
    logic [RUN_W-1:0]         n_run;
    logic                     res_full;
    logic                     fire;
    logic                     has_res;
    t_result                  res;
    logic [$bits(t_result)-1:0] res_q;

    assign fire      = !i_cmd_empty && !res_full;
    assign o_cmd_pop = fire;

    // width measurement and failsafe band check
    always_comb begin
        idx     = i_cmd.ch[CH_W-1:0];
        diff    = i_cmd.ts - r_rise_time[idx];
        width   = (diff > TS_W'(PULSE_MAX)) ? 16'hFFFF : diff[15:0];
        fs      = i_fs[i_cmd.ch];
        fs_x    = {fs[FS_W-1], fs};
        fs_lo   = fs_x - (FS_W+1)'(FS_TOL_US);
        fs_hi   = fs_x + (FS_W+1)'(FS_TOL_US);
        w_x     = {2'b00, width};
        in_band = !fs[FS_W-1] && (w_x > fs_lo) && (w_x < fs_hi);
        if (!in_band) begin
            n_run = '0;
        end else if (r_fs_run[idx] < RUN_W'(FS_RUN_LIMIT)) begin
            n_run = r_fs_run[idx] + 1'b1;
        end else begin
            n_run = r_fs_run[idx];
        end
    end

    // watchdog and failsafe flags for a query
    always_comb begin
        wd   = i_wd[i_cmd.ch];
        lost = !wd[WD_W-1] && (diff > TS_W'(wd[WD_W-2:0]));
        fsa  = (r_fs_run[idx] >= RUN_W'(FS_RUN_LIMIT));
    end

    // result formatting
    always_comb begin
        res     = '0;
        res.ch  = i_cmd.ch;
        has_res = 1'b0;
        case (i_cmd.mode)
            MODE_FALL: begin
                has_res   = 1'b1;
                res.kind  = KIND_PULSE;
                res.pulse = {1'b0, width};
            end
            MODE_QUERY: begin
                has_res  = 1'b1;
                res.kind = KIND_QUERY;
                if (i_cmd.ch_ok) begin
                    res.lost  = lost;
                    res.fsa   = fsa;
                    res.pulse = (lost || fsa) ? '1 : r_last_pulse[idx];
                end else begin
                    res.pulse = '1;
                end
            end
            default: has_res = 1'b0;
        endcase
    end

    // per-channel capture state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_rise_time[i]  <= '0;
                r_last_pulse[i] <= '1;
                r_fs_run[i]     <= '0;
            end
        end else if (fire) begin
            case (i_cmd.mode)
                MODE_RISE: begin
                    r_rise_time[idx] <= i_cmd.ts;
                end
                MODE_FALL: begin
                    r_last_pulse[idx] <= {1'b0, width};
                    r_fs_run[idx]     <= n_run;
                end
                default: ;
            endcase
        end
    end

    // result queue toward the receiver
    ppcf_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire && has_res),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (i_res_pop),
        .o_data  (res_q),
        .o_empty (o_res_empty)
    );

    assign o_res = t_result'(res_q);

endmodule

// ===== sv/pwm_pulse_capture_failsafe_top.sv =====
// ----------------------------------------------------------------------------
// pwm_pulse_capture_failsafe_top
// Multi-channel RC pulse-width capture with failsafe and watchdog detection.
// ----------------------------------------------------------------------------
// usage
//   input queue: drive i_mode / i_channel / i_timestamp_us and raise i_push;
//   a transaction completes on a clock edge with i_push high and o_full low.
//   rising edges store a time, falling edges report a width, queries report
//   the last width or -1 with the signal lost / failsafe flags.
//   result queue: a result is on the o_ ports while o_empty is low and is
//   taken on an edge with i_pop high. rising edges and dropped items give none.
//   order: an accepted item is registered in the command queue, then its
//   result is registered in the result queue, from where it can be popped.
//   throughput: one item per cycle while the receiver keeps up; per-channel
//   state updates on execute and each side has a two-entry queue.
//   a stalled receiver fills the result queue, then the command queue, then
//   o_full rises; nothing is lost.
//   configuration: APB, registers at 4*i, to be written only while idle; the block leaves this to the user.
//   reset (synchronous, active low): queues empty, rise times zero, last
//   widths -1, failsafe runs zero, all limits -1 (disabled).
// ----------------------------------------------------------------------------
module pwm_pulse_capture_failsafe_top #(
    parameter int CHANNELS    = ppcf_pkg::CHANNELS_DEF,
    parameter int QUEUE_DEPTH = ppcf_pkg::QUEUE_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input queue
    input  logic                                i_push,
    output logic                                o_full,
    input  logic [1:0]                          i_mode,
    input  logic [ppcf_pkg::CH_FIELD_W-1:0]     i_channel,
    input  logic [ppcf_pkg::TS_W-1:0]           i_timestamp_us,
    // result queue
    output logic                                o_empty,
    input  logic                                i_pop,
    output logic                                o_kind,
    output logic [ppcf_pkg::CH_FIELD_W-1:0]     o_channel_out,
    output logic signed [ppcf_pkg::PULSE_W-1:0] o_pulse_us,
    output logic                                o_signal_lost,
    output logic                                o_failsafe_active,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ppcf_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ppcf_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ppcf_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import ppcf_pkg::*;

    t_fs_bank fs;
    t_wd_bank wd;
    t_cmd     cmd;
    logic     cmd_empty;
    logic     cmd_pop;
    t_result  res;

    // register bank
    ppcf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_fs    (fs),
        .o_wd    (wd)
    );

    // accept and classify
    ppcf_front #(
        .CHANNELS    (CHANNELS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_mode         (i_mode),
        .i_channel      (i_channel),
        .i_timestamp_us (i_timestamp_us),
        .i_cmd_pop      (cmd_pop),
        .o_cmd          (cmd),
        .o_cmd_empty    (cmd_empty)
    );

    // execute
    ppcf_back #(
        .CHANNELS    (CHANNELS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_fs        (fs),
        .i_wd        (wd),
        .o_res       (res),
        .o_res_empty (o_empty),
        .i_res_pop   (i_pop)
    );

    assign o_kind            = res.kind;
    assign o_channel_out     = res.ch;
    assign o_pulse_us        = $signed(res.pulse);
    assign o_signal_lost     = res.lost;
    assign o_failsafe_active = res.fsa;

endmodule

// ===== verif/pwm_pulse_capture_failsafe_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_pulse_capture_failsafe_top_test
// Self-checking bench for the pulse capture block. A queue-fed driver offers
// rise, fall, query and unused-mode items with random gaps. A monitor pops
// results with random gaps and one long hold-off. Each result is compared
// with a cycle-free model of the per-channel widths, failsafe runs and
// watchdog ages. Registers are rewritten over APB between phases while the
// block is idle.
// ----------------------------------------------------------------------------
module pwm_pulse_capture_failsafe_top_test;

    import ppcf_pkg::*;

    localparam int          CH_NUM          = CHANNELS_DEF;
    localparam int          RESET_CYCLES    = 3;
    localparam int          DRAIN_CYCLES    = 10;
    localparam int          HOLD_CYCLES     = 300;
    localparam int          STALL_LIMIT     = 3000;
    localparam int          RAND_PHASES     = 6;
    localparam int          ITEMS_PER_PHASE = 180;
    localparam logic [1:0]  MODE_NONE       = 2'd3;
    localparam logic [31:0] WD_LIMIT_MAX    = 32'h00FF_FFFF;
    localparam logic [31:0] REG_DISABLE     = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  mode;
        logic [1:0]  ch;
        logic [31:0] ts;
    } t_capture_item;

    // dut ports
    logic                    i_clk;
    logic                    i_rst_n        = 1'b0;
    logic                    i_push         = 1'b0;
    logic                    o_full;
    logic [1:0]              i_mode         = '0;
    logic [CH_FIELD_W-1:0]   i_channel      = '0;
    logic [TS_W-1:0]         i_timestamp_us = '0;
    logic                    o_empty;
    logic                    i_pop          = 1'b0;
    logic                    o_kind;
    logic [CH_FIELD_W-1:0]   o_channel_out;
    logic signed [PULSE_W-1:0] o_pulse_us;
    logic                    o_signal_lost;
    logic                    o_failsafe_active;
    logic                    psel           = 1'b0;
    logic                    penable        = 1'b0;
    logic                    pwrite         = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr          = '0;
    logic [APB_DATA_W-1:0]   pwdata         = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    // stimulus and scoreboard storage
    t_capture_item pending_items[$];
    t_result       awaited_results[$];
    t_capture_item next_item;
    bit            offering      = 1'b0;
    bit            push_idle_en  = 1'b1;
    bit            pop_idle_en   = 1'b1;
    int            push_wait     = 0;
    int            pop_wait      = 0;
    int            hold_req      = 0;
    int            hold_seen     = 0;
    int            hold_left     = 0;
    int            stall_cnt     = 0;
    int            err_cnt       = 0;

    // shadow of the block: registers and per-channel state
    logic [FS_W-1:0]        fs_cfg  [CFG_CH];
    logic [WD_W-1:0]        wd_cfg  [CFG_CH];
    logic [31:0]            rise_t  [CFG_CH];
    logic [PULSE_W-1:0]     last_w  [CFG_CH];
    logic [RUN_W-1:0]       fs_run  [CFG_CH];

    pwm_pulse_capture_failsafe_top i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_push            (i_push),
        .o_full            (o_full),
        .i_mode            (i_mode),
        .i_channel         (i_channel),
        .i_timestamp_us    (i_timestamp_us),
        .o_empty           (o_empty),
        .i_pop             (i_pop),
        .o_kind            (o_kind),
        .o_channel_out     (o_channel_out),
        .o_pulse_us        (o_pulse_us),
        .o_signal_lost     (o_signal_lost),
        .o_failsafe_active (o_failsafe_active),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // shadow state after reset
    initial begin
        for (int k = 0; k < CFG_CH; k++) begin
            fs_cfg[k] = '1;
            wd_cfg[k] = '1;
            rise_t[k] = '0;
            last_w[k] = '1;
            fs_run[k] = '0;
        end
    end

    function automatic void note_error(input string msg);
        err_cnt++;
        if (err_cnt <= 10) begin
            $display("%0t mismatch: %s", $realtime, msg);
        end
    endfunction

    // idle length: mostly none, some short, a few long
    function automatic int idle_len(input bit enable);
        int r;
        r = $urandom_range(0, 99);
        if (!enable || r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // expected result of one accepted transaction
    function automatic void capture_model_step(input logic [1:0] mode,
                                               input logic [1:0] ch,
                                               input logic [31:0] ts);
        logic [31:0]        span;
        logic [PULSE_W-1:0] width;
        int                 fs;
        int                 wd;
        bit                 ok;
        t_result            res;
        ok     = (ch < CH_NUM);
        span   = ts - rise_t[ch];
        res    = '0;
        res.ch = ch;
        case (mode)
            MODE_RISE: begin
                if (ok) begin
                    rise_t[ch] = ts;
                end
            end
            MODE_FALL: begin
                if (ok) begin
                    width      = (span > PULSE_MAX) ? PULSE_W'(PULSE_MAX) : span[PULSE_W-1:0];
                    last_w[ch] = width;
                    fs         = $signed(fs_cfg[ch]);
                    // run counts widths strictly inside the tolerance window
                    if (fs >= 0 && int'(width) > fs - FS_TOL_US &&
                        int'(width) < fs + FS_TOL_US) begin
                        if (fs_run[ch] < FS_RUN_LIMIT) begin
                            fs_run[ch]++;
                        end
                    end else begin
                        fs_run[ch] = '0;
                    end
                    res.kind  = KIND_PULSE;
                    res.pulse = width;
                    awaited_results.push_back(res);
                end
            end
            MODE_QUERY: begin
                res.kind  = KIND_QUERY;
                res.pulse = '1;
                if (ok) begin
                    wd        = $signed(wd_cfg[ch]);
                    res.lost  = (wd >= 0) && (span > unsigned'(wd));
                    res.fsa   = (fs_run[ch] >= FS_RUN_LIMIT);
                    if (!res.lost && !res.fsa) begin
                        res.pulse = last_w[ch];
                    end
                end
                awaited_results.push_back(res);
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void check_result();
        t_result want;
        if (awaited_results.size() == 0) begin
            note_error($sformatf("unexpected result kind %0b ch %0d pulse %0d lost %0b fsa %0b",
                                 o_kind, o_channel_out, o_pulse_us, o_signal_lost,
                                 o_failsafe_active));
        end else begin
            want = awaited_results.pop_front();
            if (o_kind !== want.kind || o_channel_out !== want.ch ||
                o_pulse_us !== want.pulse || o_signal_lost !== want.lost ||
                o_failsafe_active !== want.fsa) begin
                note_error($sformatf({"exp kind %0b ch %0d pulse %0d lost %0b fsa %0b, ",
                                      "got kind %0b ch %0d pulse %0d lost %0b fsa %0b"},
                                     want.kind, want.ch, $signed(want.pulse), want.lost,
                                     want.fsa, o_kind, o_channel_out, o_pulse_us,
                                     o_signal_lost, o_failsafe_active));
            end
        end
    endfunction

    // input driver: offers queued items, holds each until accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_push    <= 1'b0;
            push_wait = 0;
            offering  = 1'b0;
        end else begin
            if (i_push && !o_full) begin
                capture_model_step(i_mode, i_channel, i_timestamp_us);
                push_wait = idle_len(push_idle_en);
                offering  = 1'b0;
            end
            if (i_push && o_full) begin
                // keep offering the same transaction
            end else if (push_wait > 0) begin
                push_wait--;
                i_push <= 1'b0;
            end else if (pending_items.size() > 0) begin
                next_item      = pending_items.pop_front();
                offering       = 1'b1;
                i_push         <= 1'b1;
                i_mode         <= next_item.mode;
                i_channel      <= next_item.ch;
                i_timestamp_us <= next_item.ts;
            end else begin
                i_push <= 1'b0;
            end
        end
    end

    // result monitor: pops with random gaps and an occasional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_pop     <= 1'b0;
            pop_wait  = 0;
            hold_left = 0;
            hold_seen = 0;
        end else begin
            if (i_pop && !o_empty) begin
                check_result();
                pop_wait = idle_len(pop_idle_en);
            end
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_pop <= 1'b0;
            end else if (pop_wait > 0) begin
                pop_wait--;
                i_pop <= 1'b0;
            end else begin
                i_pop <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any accepted transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_push && !o_full) || (i_pop && !o_empty)) begin
            stall_cnt = 0;
        end else begin
            stall_cnt++;
            if (stall_cnt >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    function automatic void add_item(input logic [1:0] mode, input logic [1:0] ch,
                                     input logic [31:0] ts);
        t_capture_item it;
        it.mode = mode;
        it.ch   = ch;
        it.ts   = ts;
        pending_items.push_back(it);
    endfunction

    // apb write: setup then access, shadow updated at the write edge
    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx < REG_WD_CH0) begin
            fs_cfg[idx[1:0]] = val[FS_W-1:0];
        end else begin
            wd_cfg[idx[1:0]] = val[WD_W-1:0];
        end
    endtask

    // all items taken, all results back, then let a trailing rise edge settle
    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_items.size() != 0 || offering || awaited_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // sequencer
    initial begin
        int          phase;
        int          n;
        int          burst;
        int          fs;
        int          wd;
        int          w;
        int          age;
        int          r;
        bit          steady;
        logic [1:0]  c;
        logic [31:0] t;
        logic [31:0] wl;
        logic [31:0] fsv;
        logic [31:0] wdv;
        logic [31:0] gen_now  [CFG_CH];
        logic [31:0] gen_rise [CFG_CH];

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset settings: empty history, zero width, wrap, saturation
        add_item(MODE_QUERY, 2'd0, 32'h0000_0000);
        add_item(MODE_FALL,  2'd1, 32'h0000_0000);
        add_item(MODE_RISE,  2'd2, 32'hFFFF_FFF0);
        add_item(MODE_FALL,  2'd2, 32'h0000_0005);
        add_item(MODE_RISE,  2'd3, 32'd1000);
        add_item(MODE_FALL,  2'd3, 32'd1000 + PULSE_MAX);
        add_item(MODE_RISE,  2'd3, 32'h0000_0000);
        add_item(MODE_FALL,  2'd3, 32'hFFFF_FFFF);
        add_item(MODE_RISE,  2'd0, 32'h8000_0000);
        add_item(MODE_FALL,  2'd0, 32'h8000_05DC);
        add_item(MODE_NONE,  2'd0, 32'hFFFF_FFFF);
        add_item(MODE_NONE,  2'd3, 32'h0000_0000);
        for (int k = 0; k < CFG_CH; k++) begin
            add_item(MODE_QUERY, 2'(k), 32'hFFFF_FFFF);
        end
        wait_idle();

        // directed, tolerance window edges and watchdog boundary
        cfg_write(REG_FS_CH0,        32'd1000);
        cfg_write(REG_WD_CH0,        32'd100);
        cfg_write(REG_FS_CH0 + 3'd1, 32'd0);
        cfg_write(REG_WD_CH0 + 3'd1, 32'd0);
        add_item(MODE_RISE,  2'd0, 32'd0);
        add_item(MODE_FALL,  2'd0, 32'd990);
        add_item(MODE_RISE,  2'd0, 32'd2000);
        add_item(MODE_FALL,  2'd0, 32'd2991);
        add_item(MODE_QUERY, 2'd0, 32'd2100);
        add_item(MODE_QUERY, 2'd0, 32'd2101);
        add_item(MODE_RISE,  2'd1, 32'd50);
        add_item(MODE_FALL,  2'd1, 32'd50);
        add_item(MODE_QUERY, 2'd1, 32'd51);
        wait_idle();

        for (int k = 0; k < CFG_CH; k++) begin
            gen_now[k]  = $urandom;
            gen_rise[k] = gen_now[k];
        end

        for (phase = 1; phase <= RAND_PHASES; phase++) begin
            // register settings: maxima, zeros, typical, negatives, then mixed
            for (int k = 0; k < CFG_CH; k++) begin
                case (phase)
                    1: begin
                        fsv = PULSE_MAX;
                        wdv = WD_LIMIT_MAX;
                    end
                    2: begin
                        fsv = '0;
                        wdv = '0;
                    end
                    3: begin
                        fsv = $urandom_range(500, 2500);
                        wdv = $urandom_range(0, 30000);
                    end
                    4: begin
                        fsv = $urandom | 32'h0001_0000;
                        wdv = $urandom | 32'h0100_0000;
                    end
                    default: begin
                        r   = $urandom_range(0, 3);
                        fsv = (r == 0) ? REG_DISABLE : (r == 1) ? 32'd0 :
                              (r == 2) ? 32'(PULSE_MAX) : 32'($urandom_range(0, 3000));
                        r   = $urandom_range(0, 3);
                        wdv = (r == 0) ? REG_DISABLE : (r == 1) ? 32'd0 :
                              (r == 2) ? WD_LIMIT_MAX : 32'($urandom_range(0, 50000));
                    end
                endcase
                cfg_write(REG_FS_CH0 + 3'(k), fsv);
                cfg_write(REG_WD_CH0 + 3'(k), wdv);
            end

            // phase 2 runs without gaps, phase 3 backs up the result side
            @(negedge i_clk);
            push_idle_en = (phase != 2 && phase != 3);
            pop_idle_en  = (phase != 2);
            if (phase == 3) begin
                hold_req++;
            end

            n = 0;
            while (n < ITEMS_PER_PHASE) begin
                c  = 2'($urandom_range(0, 3));
                fs = $signed(fs_cfg[c]);
                wd = $signed(wd_cfg[c]);
                if ($urandom_range(0, 99) < 12) begin
                    // noise: any mode, any time
                    add_item(2'($urandom_range(0, 3)), c, $urandom);
                    n++;
                end else begin
                    // pulse train, steady ones sit on the failsafe value
                    steady = (fs >= 0) && ($urandom_range(0, 99) < 45);
                    burst  = steady ? $urandom_range(15, 30) : $urandom_range(1, 8);
                    repeat (burst) begin
                        r = $urandom_range(0, 99);
                        w = fs + int'($urandom_range(0, 24)) - 12;
                        if (steady && r < 90) begin
                            w = fs + int'($urandom_range(0, 18)) - 9;
                        end
                        if (w < 0) begin
                            w = 0;
                        end
                        wl = w;
                        if (!steady) begin
                            if (r < 40 || (r >= 75 && r < 85 && fs < 0)) begin
                                wl = $urandom_range(900, 2100);
                            end else if (r < 55) begin
                                wl = $urandom_range(0, 30);
                            end else if (r < 75) begin
                                wl = $urandom_range(60000, 70000);
                            end else if (r >= 85) begin
                                wl = $urandom;
                            end
                        end
                        t = gen_now[c] + $urandom_range(3000, 25000);
                        add_item(MODE_RISE, c, t);
                        add_item(MODE_FALL, c, t + wl);
                        gen_rise[c] = t;
                        gen_now[c]  = t + wl;
                        n += 2;
                        // occasional query, often right at the watchdog limit
                        if ($urandom_range(0, 3) == 0) begin
                            if (wd >= 0 && $urandom_range(0, 1) == 1) begin
                                age = wd + int'($urandom_range(0, 4)) - 2;
                            end else begin
                                age = $urandom_range(0, 40000);
                            end
                            if (age < 0) begin
                                age = 0;
                            end
                            add_item(MODE_QUERY, c, gen_rise[c] + 32'(age));
                            n++;
                        end
                    end
                end
            end
            wait_idle();
        end

        if (awaited_results.size() != 0) begin
            note_error($sformatf("%0d results never arrived", awaited_results.size()));
        end
        if (err_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
